// File: hdl/assert_macros.svh
// Assertion helpers included by the normal generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: hdl/hng_pkg.sv
// ----------------------------------------------------------------------------
// hng_pkg
// Shared constants for the height map normal generator.
// ----------------------------------------------------------------------------
package hng_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 4096;
   localparam int FRAC_BITS  = 14;

   localparam int COL_W  = 8;
   localparam int ROW_W  = 13;
   localparam int LINE_W = 12;
   localparam int PIX_W  = 8;
   localparam int CW_W   = 9;
   localparam int CH_W   = 13;
   localparam int Z_W    = 16;
   localparam int NX_W   = 16;
   localparam int NZ_W   = 15;

   localparam int ADDR_W = 4;
   localparam int DATA_W = 32;

   localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] REG_Z_TERM       = 2'd2;

   localparam logic [CW_W-1:0] WIDTH_RESET  = CW_W'(256);
   localparam logic [CH_W-1:0] HEIGHT_RESET = CH_W'(256);
   localparam logic [Z_W-1:0]  Z_RESET      = Z_W'(2048);

endpackage

// File: hdl/hng_stream_if.sv
// ----------------------------------------------------------------------------
// hng_stream_if
// Input and result channels of the height map normal generator.
// ----------------------------------------------------------------------------
interface hng_req_if;
   logic                      valid;
   logic                      ready;
   logic                      mode;
   logic [hng_pkg::PIX_W-1:0] height_pixel;

   modport source (output valid, mode, height_pixel, input ready);
   modport sink   (input valid, mode, height_pixel, output ready);
endinterface

interface hng_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [hng_pkg::NX_W-1:0]   normal_x;
   logic signed [hng_pkg::NX_W-1:0]   normal_y;
   logic        [hng_pkg::NZ_W-1:0]   normal_z;
   logic        [hng_pkg::COL_W-1:0]  column;
   logic        [hng_pkg::LINE_W-1:0] line;
   logic                              frame_last;

   modport source (output valid, normal_x, normal_y, normal_z, column, line, frame_last,
                   input ready);
   modport sink   (input valid, normal_x, normal_y, normal_z, column, line, frame_last,
                   output ready);
endinterface

// File: hdl/heightmap_normal_generator.sv
// ----------------------------------------------------------------------------
// heightmap_normal_generator
// Central difference height map to unit normal map, two line memories.
// ----------------------------------------------------------------------------
// channel   dir   handshake        payload
// req_if    in    valid/ready      mode, height_pixel
// rsp_if    out   valid/ready      normal_x/y/z, column, line, frame_last
// csr       in    APB, pready=1    image_width, image_height, z_term
//
// One item at a time. A dropped flush is taken in S_IDLE; an item with no
// result passes S_CALC only; an item with a result passes S_CALC, S_SQ, S_SUM,
// S_NORM (skipped when x, y and z are all zero) and S_OUT, plus any wait on rsp_if:
// the normalizer tests one root bit per cycle, 16 bits for each of 3 components.
// Reset is synchronous; line memories are not cleared.
// The result register frees the input side once loaded; a stalled result only
// holds the next item at its final step.
`include "assert_macros.svh"

module heightmap_normal_generator (
   input  logic                        clock,
   input  logic                        reset,
   hng_req_if.sink                     req_if,
   hng_rsp_if.source                   rsp_if,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [hng_pkg::ADDR_W-1:0]  paddr,
   input  logic [hng_pkg::DATA_W-1:0]  pwdata,
   output logic [hng_pkg::DATA_W-1:0]  prdata,
   output logic                        pready
);
   import hng_pkg::*;

   localparam int S_W   = 35;           // sum of squares
   localparam int K_W   = 16;           // root candidate
   localparam int Q_W   = K_W + S_W;    // k * s
   localparam int ACC_W = 70;           // trial accumulator
   localparam int RHS_W = 62;

   typedef enum logic [2:0] {
      S_IDLE, S_CALC, S_SQ, S_SUM, S_NORM, S_OUT
   } state_type;

   state_type state_ff;

   // configuration
   logic [CW_W-1:0] cfg_width_ff;
   logic [CH_W-1:0] cfg_height_ff;
   logic [Z_W-1:0]  z_term_ff;
   logic [1:0]      reg_idx;
   logic            cfg_wr;

   // stream position
   logic [COL_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;
   logic [PIX_W-1:0] left_ff;

   // line memories
   logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
   logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
   logic [PIX_W-1:0] up_rd_ff, mid_rd_ff;
   logic [PIX_W-1:0] mid_prev_ff;   // middle[pc] for the coming step
   logic [PIX_W-1:0] lft_ff;        // upper[pc-1], written last step

   // item in flight
   logic [COL_W-1:0]  pc_ff;
   logic [ROW_W-1:0]  pr_ff;
   logic              wr_ff, valid_ff, last_ff;
   logic [PIX_W-1:0]  dn_src_ff;

   // arithmetic
   logic signed [8:0] dx_ff, dy_ff;
   logic [15:0]       sqx_ff, sqy_ff;
   logic [31:0]       sqz_ff;
   logic [S_W-1:0]    s_ff;
   logic [ACC_W-1:0]  p_ff;
   logic [Q_W-1:0]    qa_ff;
   logic [K_W-1:0]    k_ff;
   logic [3:0]        bit_ff;
   logic [1:0]        comp_ff;
   logic [NZ_W-1:0]   qx_ff, qy_ff, qz_ff;

   // result register
   logic                     rsp_valid_ff;
   logic signed [NX_W-1:0]   out_x_ff, out_y_ff;
   logic [NZ_W-1:0]          out_z_ff;
   logic [COL_W-1:0]         out_col_ff;
   logic [LINE_W-1:0]        out_line_ff;
   logic                     out_last_ff;

   // ---------------------------------------------------------------- config
   assign pready  = 1'b1;
   assign reg_idx = paddr[3:2];
   assign cfg_wr  = psel && penable && pwrite;

   always_comb begin
      case (reg_idx)
         REG_IMAGE_WIDTH:  prdata = DATA_W'(cfg_width_ff);
         REG_IMAGE_HEIGHT: prdata = DATA_W'(cfg_height_ff);
         REG_Z_TERM:       prdata = DATA_W'(z_term_ff);
         default:          prdata = '0;
      endcase
   end

   // clamped sizes
   logic [CW_W-1:0] w;
   logic [CH_W-1:0] h;
   always_comb begin
      w = cfg_width_ff;
      if (w < CW_W'(2)) w = CW_W'(2);
      if (w > CW_W'(MAX_WIDTH)) w = CW_W'(MAX_WIDTH);
      h = cfg_height_ff;
      if (h < CH_W'(2)) h = CH_W'(2);
      if (h > CH_W'(MAX_HEIGHT)) h = CH_W'(MAX_HEIGHT);
   end

   // ------------------------------------------------------- item decode
   logic [COL_W-1:0] c_eff, pc, mid_addr;
   logic [ROW_W-1:0] pr;
   logic             drain, ignore, wr_en, pos_valid, last;
   logic [PIX_W-1:0] value;
   logic [CW_W-1:0]  c_inc, pc_inc;
   logic             accept;

   always_comb begin
      c_eff     = ({1'b0, col_ff} >= w) ? COL_W'(w - CW_W'(1)) : col_ff;
      drain     = {1'b0, row_ff} >= {1'b0, h};
      ignore    = !drain && req_if.mode;
      value     = drain ? '0 : req_if.height_pixel;
      wr_en     = (c_eff != '0) || (row_ff != '0);
      if (c_eff != '0) begin
         pc        = c_eff - COL_W'(1);
         pr        = row_ff - ROW_W'(1);
         pos_valid = (row_ff >= ROW_W'(1)) && ({1'b0, row_ff} <= {1'b0, h});
      end else begin
         pc        = COL_W'(w - CW_W'(1));
         pr        = row_ff - ROW_W'(2);
         pos_valid = (row_ff >= ROW_W'(2)) &&
                     ({1'b0, row_ff} <= ({1'b0, h} + (ROW_W+1)'(1)));
      end
      last     = pos_valid && (pr == ROW_W'(h - CH_W'(1)))
                 && ({1'b0, pc} == w - CW_W'(1));
      pc_inc   = {1'b0, pc} + CW_W'(1);
      mid_addr = (pc_inc == w) ? '0 : pc_inc[COL_W-1:0];
      c_inc    = {1'b0, c_eff} + CW_W'(1);
   end

   assign req_if.ready = (state_ff == S_IDLE);
   assign accept       = req_if.valid && req_if.ready;

   // ------------------------------------------------------- line memories
   always_ff @(posedge clock) begin
      up_rd_ff  <= upper_mem[pc];
      mid_rd_ff <= middle_mem[mid_addr];
      if (state_ff == S_CALC && wr_ff) begin
         upper_mem[pc_ff]  <= mid_prev_ff;
         middle_mem[pc_ff] <= dn_src_ff;
      end
   end

   // ------------------------------------------------------- window terms
   logic [PIX_W-1:0] t_lft, t_rgt, t_up, t_dn;
   always_comb begin
      t_lft = (pc_ff != '0) ? lft_ff : '0;
      t_rgt = (({1'b0, pc_ff} + CW_W'(1)) < w) ? mid_rd_ff : '0;
      t_up  = (pr_ff != '0) ? up_rd_ff : '0;
      t_dn  = (({1'b0, pr_ff} + (ROW_W+1)'(1)) < (ROW_W+1)'(h)) ? dn_src_ff : '0;
   end

   // ------------------------------------------------------- root bit step
   // k is the largest root with k*k*s <= m*m*2^30; q = (k+1)/2.
   logic [RHS_W-1:0] rhs;
   logic [ACC_W-1:0] trial;
   logic             take;
   logic [K_W-1:0]   k_in;
   logic [K_W:0]     k_rnd;
   logic [NZ_W-1:0]  q_in;

   always_comb begin
      case (comp_ff)
         2'd0:    rhs = {sqx_ff, 46'b0};
         2'd1:    rhs = {sqy_ff, 46'b0};
         default: rhs = {sqz_ff, 30'b0};
      endcase
      trial = p_ff + (ACC_W'({qa_ff, 1'b0}) << bit_ff)
                   + (ACC_W'(s_ff) << {bit_ff, 1'b0});
      take  = trial <= ACC_W'(rhs);
      k_in  = take ? (k_ff | (K_W'(1) << bit_ff)) : k_ff;
      k_rnd = {1'b0, k_in} + (K_W+1)'(1);
      q_in  = k_rnd[NZ_W:1];
   end

   // ------------------------------------------------------- sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cfg_width_ff  <= WIDTH_RESET;
         cfg_height_ff <= HEIGHT_RESET;
         z_term_ff     <= Z_RESET;
         col_ff        <= '0;
         row_ff        <= '0;
         left_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_if.ready) rsp_valid_ff <= 1'b0;

         if (cfg_wr) begin
            case (reg_idx)
               REG_IMAGE_WIDTH: begin
                  cfg_width_ff <= pwdata[CW_W-1:0];
                  col_ff <= '0; row_ff <= '0; left_ff <= '0;
               end
               REG_IMAGE_HEIGHT: begin
                  cfg_height_ff <= pwdata[CH_W-1:0];
                  col_ff <= '0; row_ff <= '0; left_ff <= '0;
               end
               REG_Z_TERM: z_term_ff <= pwdata[Z_W-1:0];
               default: ;
            endcase
         end

         case (state_ff)
            S_IDLE: begin
               if (accept && !ignore) begin
                  pc_ff     <= pc;
                  pr_ff     <= pr;
                  wr_ff     <= wr_en;
                  valid_ff  <= pos_valid;
                  last_ff   <= last;
                  dn_src_ff <= left_ff;
                  // advance position; frame end restarts it
                  if (last) begin
                     col_ff <= '0; row_ff <= '0; left_ff <= '0;
                  end else begin
                     left_ff <= value;
                     if (c_inc >= w) begin
                        col_ff <= '0;
                        row_ff <= row_ff + ROW_W'(1);
                     end else begin
                        col_ff <= c_inc[COL_W-1:0];
                     end
                  end
                  state_ff <= S_CALC;
               end
            end
            S_CALC: begin
               lft_ff      <= mid_prev_ff;
               mid_prev_ff <= mid_rd_ff;
               dx_ff <= $signed({1'b0, t_lft}) - $signed({1'b0, t_rgt});
               dy_ff <= $signed({1'b0, t_up}) - $signed({1'b0, t_dn});
               state_ff <= valid_ff ? S_SQ : S_IDLE;
            end
            S_SQ: begin
               sqx_ff <= 16'(dx_ff * dx_ff);
               sqy_ff <= 16'(dy_ff * dy_ff);
               sqz_ff <= z_term_ff * z_term_ff;
               state_ff <= S_SUM;
            end
            S_SUM: begin
               s_ff    <= S_W'({sqx_ff, 16'b0}) + S_W'({sqy_ff, 16'b0}) + S_W'(sqz_ff);
               p_ff    <= '0;
               qa_ff   <= '0;
               k_ff    <= '0;
               bit_ff  <= 4'd15;
               comp_ff <= 2'd0;
               if (sqx_ff == '0 && sqy_ff == '0 && sqz_ff == '0) begin
                  qx_ff    <= '0;
                  qy_ff    <= '0;
                  qz_ff    <= NZ_W'(1 << FRAC_BITS);
                  state_ff <= S_OUT;
               end else begin
                  state_ff <= S_NORM;
               end
            end
            S_NORM: begin
               if (take) begin
                  p_ff  <= trial;
                  qa_ff <= qa_ff + (Q_W'(s_ff) << bit_ff);
               end
               k_ff <= k_in;
               if (bit_ff == 4'd0) begin
                  case (comp_ff)
                     2'd0:    qx_ff <= q_in;
                     2'd1:    qy_ff <= q_in;
                     default: qz_ff <= q_in;
                  endcase
                  p_ff   <= '0;
                  qa_ff  <= '0;
                  k_ff   <= '0;
                  bit_ff <= 4'd15;
                  if (comp_ff == 2'd2) state_ff <= S_OUT;
                  else comp_ff <= comp_ff + 2'd1;
               end else begin
                  bit_ff <= bit_ff - 4'd1;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_if.ready) begin
                  rsp_valid_ff <= 1'b1;
                  out_x_ff     <= dx_ff[8] ? -$signed(NX_W'(qx_ff)) : $signed(NX_W'(qx_ff));
                  out_y_ff     <= dy_ff[8] ? -$signed(NX_W'(qy_ff)) : $signed(NX_W'(qy_ff));
                  out_z_ff     <= qz_ff;
                  out_col_ff   <= pc_ff;
                  out_line_ff  <= pr_ff[LINE_W-1:0];
                  out_last_ff  <= last_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.normal_x   = out_x_ff;
   assign rsp_if.normal_y   = out_y_ff;
   assign rsp_if.normal_z   = out_z_ff;
   assign rsp_if.column     = out_col_ff;
   assign rsp_if.line       = out_line_ff;
   assign rsp_if.frame_last = out_last_ff;

   // ------------------------------------------------------- assertions
   `ASSERT_NEXT(a_accept_to_calc, accept && !ignore, state_ff == S_CALC)
   `ASSERT_NEXT(a_norm_done, state_ff == S_NORM && bit_ff == 4'd0 && comp_ff == 2'd2,
                state_ff == S_OUT)
   `ASSERT_NOW(a_unit_bound, state_ff == S_OUT,
               qx_ff <= NZ_W'(1 << FRAC_BITS) && qz_ff <= NZ_W'(1 << FRAC_BITS))
   `ASSERT_NOW(a_row_bound, state_ff == S_IDLE,
               {1'b0, row_ff} <= ({1'b0, h} + (ROW_W+1)'(1)))

endmodule

// File: verif/hng_normal_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hng_normal_checker
// Watches the pixel, normal and register ports of the normal generator,
// tracks frame position and line stores, computes the unit normal expected
// for each accepted pixel and compares every result against it in order.
// ----------------------------------------------------------------------------
module hng_normal_checker (
   input  logic                       clock,
   input  logic                       reset,
   hng_req_if                         req,
   hng_rsp_if                         rsp,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [hng_pkg::ADDR_W-1:0] paddr,
   input  logic [hng_pkg::DATA_W-1:0] pwdata,
   input  logic                       pready,
   output int                         error_count,
   output int                         pending
);
   import hng_pkg::*;

   typedef struct packed {
      logic [NX_W-1:0]   nx;
      logic [NX_W-1:0]   ny;
      logic [NZ_W-1:0]   nz;
      logic [COL_W-1:0]  col;
      logic [LINE_W-1:0] ln;
      logic              last;
   } normal_type;

   normal_type        normals_due[$];
   logic [PIX_W-1:0]  upper_row[MAX_WIDTH];
   logic [PIX_W-1:0]  middle_row[MAX_WIDTH];
   logic [PIX_W-1:0]  left_pix;
   int                in_col, in_row, drained;
   logic [CW_W-1:0]   width_reg;
   logic [CH_W-1:0]   height_reg;
   logic [Z_W-1:0]    z_reg;

   assign pending = normals_due.size();

   // round half up of mag * 2^F / sqrt(s), by exact bit-serial root test
   function automatic int unit_part(longint unsigned mag, longint unsigned s);
      logic [127:0] rhs;
      logic [127:0] lhs;
      longint unsigned q, cand, odd;
      rhs = (128'(mag) * 128'(mag)) << (2 * FRAC_BITS + 2);
      q = 0;
      for (int b = FRAC_BITS; b >= 0; b--) begin
         cand = q | (64'd1 << b);
         odd  = 2 * cand - 1;
         lhs  = 128'(odd * odd) * 128'(s);
         if (lhs <= rhs) q = cand;
      end
      return int'(q);
   endfunction

   function automatic logic [NX_W-1:0] signed_part(longint d, longint unsigned s);
      int q;
      q = unit_part(d < 0 ? -d : d, s);
      return d < 0 ? NX_W'(-q) : NX_W'(q);
   endfunction

   function automatic void new_frame();
      in_col = 0; in_row = 0; drained = 0; left_pix = '0;
   endfunction

   function automatic void take_pixel(logic mode, logic [PIX_W-1:0] pix);
      int w, h, c, r, pr, pc, col;
      bit drain, hit;
      longint lft, rgt, up, dn, x, y;
      longint unsigned z, s;
      normal_type e;
      w = width_reg;  h = height_reg;
      if (w < 2) w = 2;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      if (h < 2) h = 2;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      c = in_col; r = in_row;
      if (c >= w) c = w - 1;
      drain = r >= h;
      if (!drain && mode) return;   // early flush: ignored
      e = '0;
      if (c >= 1) begin
         hit = r >= 1 && r - 1 < h; pr = r - 1; pc = c - 1;
      end else begin
         hit = r >= 2 && r - 2 < h; pr = r - 2; pc = w - 1;
      end
      if (hit) begin
         // neighbors outside the image count as zero
         lft = pc >= 1 ? upper_row[pc-1] : 0;
         rgt = pc + 1 < w ? middle_row[pc+1] : 0;
         up  = pr >= 1 ? upper_row[pc] : 0;
         dn  = pr + 1 < h ? left_pix : 0;
         x = (lft - rgt) * 256;
         y = (up - dn) * 256;
         z = z_reg;
         s = x * x + y * y + z * z;
         if (s == 0) begin
            e.nz = NZ_W'(1 << FRAC_BITS);
         end else begin
            e.nx = signed_part(x, s);
            e.ny = signed_part(y, s);
            e.nz = NZ_W'(unit_part(z, s));
         end
         e.last = pr == h - 1 && pc == w - 1;
         e.col  = COL_W'(pc);
         e.ln   = LINE_W'(pr);
         normals_due.push_back(e);
      end
      // previous pixel lands in its column one item late
      if (c >= 1 || r >= 1) begin
         col = c >= 1 ? c - 1 : w - 1;
         upper_row[col]  = middle_row[col];
         middle_row[col] = left_pix;
      end
      left_pix = drain ? '0 : pix;
      if (drain) drained = (drained + 1) & 9'h1ff;
      c++;
      if (c >= w) begin
         c = 0; r++;
      end
      in_col = c; in_row = r;
      if (hit && e.last) new_frame();
   endfunction

   always @(posedge clock) begin
      normal_type e;
      if (reset) begin
         normals_due.delete();
         error_count <= 0;
         for (int i = 0; i < MAX_WIDTH; i++) begin
            upper_row[i] = '0; middle_row[i] = '0;
         end
         new_frame();
         width_reg = WIDTH_RESET; height_reg = HEIGHT_RESET; z_reg = Z_RESET;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (normals_due.size() == 0) begin
               $error("normal at col %0d line %0d with none expected", rsp.column, rsp.line);
               error_count <= error_count + 1;
            end else begin
               e = normals_due.pop_front();
               if (rsp.normal_x !== e.nx || rsp.normal_y !== e.ny || rsp.normal_z !== e.nz
                   || rsp.column !== e.col || rsp.line !== e.ln
                   || rsp.frame_last !== e.last)
                  error_count <= error_count + 1;
               if (rsp.normal_x !== e.nx)
                  $error("normal_x expected %0d got %0d", $signed(e.nx), rsp.normal_x);
               if (rsp.normal_y !== e.ny)
                  $error("normal_y expected %0d got %0d", $signed(e.ny), rsp.normal_y);
               if (rsp.normal_z !== e.nz)
                  $error("normal_z expected %0d got %0d", e.nz, rsp.normal_z);
               if (rsp.column !== e.col)
                  $error("column expected %0d got %0d", e.col, rsp.column);
               if (rsp.line !== e.ln)
                  $error("line expected %0d got %0d", e.ln, rsp.line);
               if (rsp.frame_last !== e.last)
                  $error("frame_last expected %0d got %0d", e.last, rsp.frame_last);
            end
         end
         if (psel && penable && pwrite && pready) begin
            case (paddr[ADDR_W-1:2])
               REG_IMAGE_WIDTH: begin
                  width_reg = pwdata[CW_W-1:0]; new_frame();
               end
               REG_IMAGE_HEIGHT: begin
                  height_reg = pwdata[CH_W-1:0]; new_frame();
               end
               REG_Z_TERM: z_reg = pwdata[Z_W-1:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) take_pixel(req.mode, req.height_pixel);
      end
   end

endmodule

// File: verif/heightmap_normal_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightmap_normal_generator_tb
// Streams height frames of many sizes through the normal generator with
// random gaps and stalls, including early flushes and stray pixels in the
// drain phase; a checker beside the block predicts every normal.
// ----------------------------------------------------------------------------
module heightmap_normal_generator_tb;
   import hng_pkg::*;

   localparam int IDLE_LIMIT = 5000;   // cycles with no handshake at all
   localparam int SETTLE     = 60;     // > one full normalizer pass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0] pwdata = '0;
   logic [DATA_W-1:0] prdata;
   logic              pready;
   int                error_count, pending;
   int                items_sent = 0;
   int                idle_cycles = 0;
   bit                calm = 1'b0;     // stretches with no gaps on either side

   hng_req_if req_ch();
   hng_rsp_if rsp_ch();

   heightmap_normal_generator dut (
      .clock, .reset, .req_if(req_ch), .rsp_if(rsp_ch),
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   hng_normal_checker chk (
      .clock, .reset, .req(req_ch), .rsp(rsp_ch),
      .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
      .error_count, .pending
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int gap_draw();
      return calm ? 0 : $urandom_range(0, 11);
   endfunction

   // watchdog: any handshake on any port resets the count
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (psel && penable))
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("** heightmap_normal_generator: FAILED **");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   // result side: random stalls, one long hold-off early on
   initial begin
      int n, taken;
      taken = 0;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         n = gap_draw();
         if (taken == 40) n = 400;   // let the block back up into the input
         if (n > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         taken++;
         @(negedge clock);
      end
   end

   task automatic reg_write(logic [1:0] idx, logic [DATA_W-1:0] value);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= ADDR_W'({idx, 2'b00}); pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   task automatic push_item(logic mode, logic [PIX_W-1:0] pix);
      int n;
      n = gap_draw();
      if (n > 0) begin
         req_ch.valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.mode <= mode;
      req_ch.height_pixel <= pix;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      items_sent++;
      if (items_sent % 60 == 0) calm = $urandom_range(0, 2) == 0;
   endtask

   // idle point: all normals in, then a normalizer pass for quiet items
   task automatic drain_wait();
      req_ch.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic set_size(int wv, int hv, int zv);
      reg_write(REG_IMAGE_WIDTH, DATA_W'(wv));
      reg_write(REG_IMAGE_HEIGHT, DATA_W'(hv));
      reg_write(REG_Z_TERM, DATA_W'(zv));
   endtask

   // style: 0 random heights, 1 only 0 / 255, 2 flat zero
   task automatic play_frame(int wv, int hv, int zv, int style, int flush_pct, int stray_pct);
      int w, h;
      logic [PIX_W-1:0] pix;
      set_size(wv, hv, zv);
      w = wv & 9'h1ff;   h = hv & 13'h1fff;
      w = w < 2 ? 2 : (w > MAX_WIDTH ? MAX_WIDTH : w);
      h = h < 2 ? 2 : (h > MAX_HEIGHT ? MAX_HEIGHT : h);
      for (int i = 0; i < w * h; i++) begin
         // early flush is dropped by the block
         if ($urandom_range(1, 100) <= flush_pct) push_item(1'b1, PIX_W'($urandom));
         case (style)
            0: pix = PIX_W'($urandom);
            1: pix = $urandom_range(0, 1) ? 8'hff : 8'h00;
            default: pix = '0;
         endcase
         push_item(1'b0, pix);
      end
      // drain: stray pixels here act as flushes
      for (int i = 0; i <= w; i++)
         push_item($urandom_range(1, 100) <= stray_pct ? 1'b0 : 1'b1, PIX_W'($urandom));
      drain_wait();
   endtask

   initial begin
      int wv, hv, zv;
      req_ch.valid = 1'b0;
      req_ch.mode = 1'b0;
      req_ch.height_pixel = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: edge heights, flat frame (zero vector), smallest frame
      play_frame(4, 3, 2048, 1, 30, 50);
      play_frame(2, 2, 0, 2, 0, 100);
      reg_write(2'd3, 32'hffff_ffff);   // unmapped register, ignored

      // tallest frame setting, abandoned part way by the next size write
      set_size(1, 8191, 65535);
      for (int i = 0; i < 12; i++) push_item(1'b0, PIX_W'($urandom));
      drain_wait();

      // widest frame, width written above range, two full rows then abandoned
      set_size(300, 4096, 0);
      for (int i = 0; i < 560; i++)
         push_item($urandom_range(0, 15) == 0, PIX_W'($urandom));
      drain_wait();

      while (items_sent < 620) begin
         wv = $urandom_range(0, 9) == 0 ? $urandom_range(0, 511) % 40 : $urandom_range(2, 10);
         hv = $urandom_range(0, 9) == 0 ? $urandom_range(0, 1) : $urandom_range(2, 6);
         case ($urandom_range(0, 4))
            0: zv = 0;
            1: zv = 65535;
            2: zv = $urandom_range(0, 4000);
            default: zv = $urandom_range(0, 65535);
         endcase
         play_frame(wv, hv, zv, $urandom_range(0, 5) == 0 ? 1 : 0,
                    $urandom_range(0, 10), $urandom_range(0, 40));
      end

      drain_wait();
      if (error_count == 0 && pending == 0)
         $display("** heightmap_normal_generator: PASSED **");
      else
         $display("** heightmap_normal_generator: FAILED **");
      $finish;
   end

endmodule
